[design/adaptive_morse_run_decoder_unit_macros.svh]
// Assertion macros shared by the decoder RTL.
// Each expects signals named clock and reset in the enclosing module.
`ifndef ADAPTIVE_MORSE_RUN_DECODER_UNIT_MACROS_SVH
`define ADAPTIVE_MORSE_RUN_DECODER_UNIT_MACROS_SVH

// same-cycle implication
`define AMRD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define AMRD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/amrd_pkg.sv]
package amrd_pkg;

   // dit estimate limits, Q11.4 ms
   localparam logic [14:0] DIT_MIN     = 15'd80;
   localparam logic [14:0] DIT_MAX     = 15'd32000;
   localparam logic [14:0] DIT_DEFAULT = 15'd960;

   // operation codes
   localparam logic [1:0] OP_RUN     = 2'd0;
   localparam logic [1:0] OP_FINISH  = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_INITIAL_DIT  = 2'd0;
   localparam logic [1:0] CSR_ALPHA_NORMAL = 2'd1;
   localparam logic [1:0] CSR_ALPHA_WARMUP = 2'd2;
   localparam logic [1:0] CSR_WARMUP_MARKS = 2'd3;

   // divide by 3 as multiply by ceil(2^21 / 3), exact below 2^21
   localparam logic [19:0] RECIP_3     = 20'd699051;
   localparam int          RECIP_SHIFT = 21;
   localparam logic [9:0]  ROUND_BIAS  = 10'd384;

   typedef enum logic [1:0] {
      UPD_IDLE,
      UPD_MUL_C,
      UPD_RECIP,
      UPD_FINISH
   } upd_state_type;

   typedef struct packed {
      logic        start;
      logic        warm;
      logic        dah;
      logic [14:0] dit;
      logic [7:0]  alpha;
      logic [15:0] duration;
   } upd_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [14:0] dit;
   } upd_rsp_type;

   function automatic logic [14:0] clamp_dit(input logic [18:0] v);
      logic [14:0] r;
      if (v < {4'b0, DIT_MIN}) begin
         r = DIT_MIN;
      end else if (v > {4'b0, DIT_MAX}) begin
         r = DIT_MAX;
      end else begin
         r = v[14:0];
      end
      return r;
   endfunction

   function automatic logic [14:0] start_dit(input logic [14:0] v);
      logic [14:0] r;
      if (v == 15'd0) begin
         r = DIT_DEFAULT;
      end else begin
         r = clamp_dit({4'b0, v});
      end
      return r;
   endfunction

endpackage

[design/amrd_dit_update.sv]
`include "adaptive_morse_run_decoder_unit_macros.svh"

module amrd_dit_update (
   input  logic                  clock,
   input  logic                  reset,
   input  amrd_pkg::upd_req_type upd_req,
   input  logic [15:0]           shortest_mark,
   output amrd_pkg::upd_rsp_type upd_rsp
);
   import amrd_pkg::*;

   upd_state_type state_ff, state_in;
   logic [39:0]   acc_ff, acc_in;
   logic [7:0]    alpha_ff, alpha_in;
   logic [17:0]   c3_ff, c3_in;
   logic          warm_ff, warm_in;

   // shared multiplier
   logic [19:0] mul_a, mul_b;
   logic [39:0] mul_p;

   logic [16:0] dit3;
   logic [17:0] c3_new;
   logic [18:0] quo;
   logic [14:0] est_avg;
   logic [16:0] half_sum;
   logic [14:0] est_half;

   assign mul_p = {20'b0, mul_a} * {20'b0, mul_b};

   assign dit3   = {2'b0, upd_req.dit} + {1'b0, upd_req.dit, 1'b0};
   assign c3_new = upd_req.dah ? {2'b0, upd_req.duration}
                               : {2'b0, upd_req.duration} + {1'b0, upd_req.duration, 1'b0};

   assign quo      = acc_ff[RECIP_SHIFT +: 19];
   assign est_avg  = clamp_dit(quo);
   assign half_sum = {2'b0, est_avg} + {1'b0, shortest_mark} + 17'd1;
   assign est_half = clamp_dit({3'b0, half_sum[16:1]});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= UPD_IDLE;
      end else begin
         state_ff <= state_in;
      end
      acc_ff   <= acc_in;
      alpha_ff <= alpha_in;
      c3_ff    <= c3_in;
      warm_ff  <= warm_in;
   end

   always_comb begin
      state_in    = state_ff;
      acc_in      = acc_ff;
      alpha_in    = alpha_ff;
      c3_in       = c3_ff;
      warm_in     = warm_ff;
      mul_a       = '0;
      mul_b       = '0;
      upd_rsp.busy = (state_ff != UPD_IDLE);
      upd_rsp.done = 1'b0;
      upd_rsp.dit  = est_avg;
      unique case (state_ff)
         UPD_IDLE: begin
            // old-estimate term: 3E * (256 - a)
            mul_a = {3'b0, dit3};
            mul_b = {11'b0, 9'd256 - {1'b0, upd_req.alpha}};
            if (upd_req.start) begin
               acc_in   = mul_p;
               alpha_in = upd_req.alpha;
               c3_in    = c3_new;
               warm_in  = upd_req.warm;
               state_in = UPD_MUL_C;
            end
         end
         UPD_MUL_C: begin
            mul_a    = {2'b0, c3_ff};
            mul_b    = {12'b0, alpha_ff};
            acc_in   = acc_ff + mul_p + {30'b0, ROUND_BIAS};
            state_in = UPD_RECIP;
         end
         UPD_RECIP: begin
            // sum / 768 = (sum >> 8) / 3
            mul_a    = {1'b0, acc_ff[26:8]};
            mul_b    = RECIP_3;
            acc_in   = mul_p;
            state_in = UPD_FINISH;
         end
         UPD_FINISH: begin
            upd_rsp.done = 1'b1;
            // warmup: pull halfway toward the shortest mark
            if (warm_ff && ({1'b0, est_avg} > shortest_mark)) begin
               upd_rsp.dit = est_half;
            end
            state_in = UPD_IDLE;
         end
      endcase
   end

   `AMRD_ASSERT_NEXT(a_start_runs, upd_req.start && state_ff == UPD_IDLE,
      state_ff == UPD_MUL_C, "update did not advance after start")
   `AMRD_ASSERT_NEXT(a_recip_done, state_ff == UPD_RECIP,
      upd_rsp.done, "update did not finish after reciprocal step")
   `AMRD_ASSERT_NOW(a_done_range, upd_rsp.done,
      upd_rsp.dit >= DIT_MIN && upd_rsp.dit <= DIT_MAX, "new estimate out of range")

endmodule

[design/adaptive_morse_run_decoder_unit.sv]
// Adaptive Morse run decoder.
// req channel: one transaction per timed run or command. req_tuser carries the
// operation (run, finish, restart) and the mark flag, req_tdata the run length
// in Q12.4 ms. rsp channel: one transaction per completed letter with its
// dit/dah pattern, length, word-space flag and the current dit estimate.
// csr port: write-only registers, taken at any edge with csr_we high; write
// them only while the block is idle. initial_dit takes effect on restart.
// Timing: a space or finish that closes a letter shows the letter on rsp in the
// cycle after acceptance. A mark's update starts at acceptance and runs three steps
// of the shared multiplier (old-estimate term, new-mark term, divide by 768
// through a reciprocal multiply), and no new request is taken until it is through;
// spaces, finish and restart are taken one per cycle while no update runs and rsp is not stalled.
// A stalled rsp holds its letter; req_tready drops until the letter drains.
// Reset restores register defaults, the 60 ms estimate and clears the letter.
`include "adaptive_morse_run_decoder_unit_macros.svh"

module adaptive_morse_run_decoder_unit #(
   parameter int MAX_SYMBOLS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [15:0] duration
   input  logic [2:0]  req_tuser,  // [1:0] op, [2] is_mark
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [0] space_before, [8:1] pattern_bits,
                                   // [12:9] pattern_len, [27:13] dit_now, zero above
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_wdata
);
   import amrd_pkg::*;

   localparam int STORE_CAP = (MAX_SYMBOLS < 8) ? MAX_SYMBOLS : 8;

   logic [14:0] cfg_initial_dit_ff;
   logic [7:0]  cfg_alpha_normal_ff;
   logic [7:0]  cfg_alpha_warmup_ff;
   logic [3:0]  cfg_warmup_marks_ff;

   logic [14:0] dit_ff, dit_in;
   logic [7:0]  store_ff, store_in;
   logic [3:0]  count_ff, count_in;
   logic        sent_ff, sent_in;
   logic        owed_ff, owed_in;
   logic [3:0]  marks_ff, marks_in;
   logic [15:0] shortest_ff, shortest_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [27:0] rsp_data_ff, rsp_data_in;

   upd_req_type upd_req;
   upd_rsp_type upd_rsp;

   logic        accept;
   logic [1:0]  op;
   logic        is_mark;
   logic [15:0] duration;
   logic [16:0] twice_dit;
   logic [17:0] five_dit;
   logic        long_run;
   logic        word_run;
   logic        warm;

   assign op       = req_tuser[1:0];
   assign is_mark  = req_tuser[2];
   assign duration = req_tdata;

   assign req_tready = !upd_rsp.busy && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign twice_dit = {1'b0, dit_ff, 1'b0};
   assign five_dit  = {1'b0, dit_ff, 2'b0} + {3'b0, dit_ff};
   assign long_run  = {1'b0, duration} >= twice_dit;
   assign word_run  = {2'b0, duration} >= five_dit;
   assign warm      = marks_ff < cfg_warmup_marks_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_data_ff};

   always_comb begin
      upd_req.start    = accept && (op == OP_RUN) && is_mark && (duration != 16'd0);
      upd_req.warm     = warm;
      upd_req.dah      = long_run;
      upd_req.dit      = dit_ff;
      upd_req.alpha    = warm ? cfg_alpha_warmup_ff : cfg_alpha_normal_ff;
      upd_req.duration = duration;
   end

   amrd_dit_update u_update (
      .clock         (clock),
      .reset         (reset),
      .upd_req       (upd_req),
      .shortest_mark (shortest_ff),
      .upd_rsp       (upd_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_initial_dit_ff  <= DIT_DEFAULT;
         cfg_alpha_normal_ff <= 8'd38;
         cfg_alpha_warmup_ff <= 8'd115;
         cfg_warmup_marks_ff <= 4'd6;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INITIAL_DIT:  cfg_initial_dit_ff  <= csr_wdata;
            CSR_ALPHA_NORMAL: cfg_alpha_normal_ff <= csr_wdata[7:0];
            CSR_ALPHA_WARMUP: cfg_alpha_warmup_ff <= csr_wdata[7:0];
            CSR_WARMUP_MARKS: cfg_warmup_marks_ff <= csr_wdata[3:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dit_ff       <= DIT_DEFAULT;
         store_ff     <= '0;
         count_ff     <= '0;
         sent_ff      <= 1'b0;
         owed_ff      <= 1'b0;
         marks_ff     <= '0;
         shortest_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dit_ff       <= dit_in;
         store_ff     <= store_in;
         count_ff     <= count_in;
         sent_ff      <= sent_in;
         owed_ff      <= owed_in;
         marks_ff     <= marks_in;
         shortest_ff  <= shortest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      logic emit;
      emit         = 1'b0;
      dit_in       = upd_rsp.done ? upd_rsp.dit : dit_ff;
      store_in     = store_ff;
      count_in     = count_ff;
      sent_in      = sent_ff;
      owed_in      = owed_ff;
      marks_in     = marks_ff;
      shortest_in  = shortest_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (accept) begin
         case (op)
            OP_RUN: begin
               if (duration != 16'd0) begin
                  if (is_mark) begin
                     if (warm) begin
                        marks_in = marks_ff + 4'd1;
                     end
                     if (shortest_ff == 16'd0 || duration < shortest_ff) begin
                        shortest_in = duration;
                     end
                     // drop symbols beyond the store
                     if (count_ff < 4'(STORE_CAP)) begin
                        store_in = store_ff | (8'(long_run) << count_ff[2:0]);
                        count_in = count_ff + 4'd1;
                     end
                  end else if (long_run) begin
                     emit = 1'b1;
                  end
               end
            end
            OP_FINISH: emit = 1'b1;
            OP_RESTART: begin
               dit_in      = start_dit(cfg_initial_dit_ff);
               store_in    = '0;
               count_in    = '0;
               sent_in     = 1'b0;
               owed_in     = 1'b0;
               marks_in    = '0;
               shortest_in = '0;
            end
            default: ;
         endcase

         if (emit && count_ff != 4'd0) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {dit_ff, count_ff, store_ff, owed_ff && sent_ff};
            owed_in      = 1'b0;
            sent_in      = 1'b1;
            store_in     = '0;
            count_in     = '0;
         end
         // owe the word space after the letter closes
         if (op == OP_RUN && !is_mark && duration != 16'd0 && word_run) begin
            owed_in = 1'b1;
         end
      end
   end

   `AMRD_ASSERT_NOW(a_dit_range, 1'b1,
      dit_ff >= DIT_MIN && dit_ff <= DIT_MAX, "dit estimate out of range")
   `AMRD_ASSERT_NOW(a_count_cap, 1'b1,
      count_ff <= 4'(STORE_CAP), "symbol count beyond store")
   `AMRD_ASSERT_NOW(a_letter_len, rsp_valid_ff,
      rsp_data_ff[12:9] != 4'd0, "empty letter on rsp")

endmodule
